// File: design/assert_macros.svh
// assertion helpers for the rtl
// each check is sampled on the rising edge of i_clk and is off while i_rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// consequent must hold in the same cycle as the antecedent
`define LAG_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define LAG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define LAG_ASSERT_SAME(lbl, ante, cons, msg)
`define LAG_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: design/lag_pkg.sv
`timescale 1ns / 1ps

package lag_pkg;

    localparam int REQ_TYPE_W = 2;
    localparam int COORD_W    = 6;
    localparam int STATE_W    = 2;

    // request codes
    localparam logic [REQ_TYPE_W-1:0] REQ_SET  = 2'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_GEN  = 2'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_READ = 2'd2;

    // read answers
    localparam logic [STATE_W-1:0] CELL_DEAD   = 2'd0;
    localparam logic [STATE_W-1:0] CELL_ALIVE  = 2'd1;
    localparam logic [STATE_W-1:0] CELL_BORDER = 2'd2;

    // b3/s23 neighbor counts
    localparam logic [3:0] NBR_BIRTH = 4'd3;
    localparam logic [3:0] NBR_KEEP  = 4'd2;

    typedef struct packed {
        logic [REQ_TYPE_W-1:0] req_type;
        logic [COORD_W-1:0]    col;
        logic [COORD_W-1:0]    row;
    } t_req_item;

    typedef struct packed {
        logic [STATE_W-1:0] cell_state;
        logic               step_done;
    } t_rsp_item;

    typedef struct packed {
        logic cap;
        logic cnt_clr;
        logic cnt_inc;
        logic rd_req;
        logic rd_gen;
        logic wr_clear;
        logic wr_set;
        logic wr_gen;
        logic flip;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic gen_last;
        logic out_free;
    } t_sts;

endpackage

// File: design/lag_stream_if.sv
`timescale 1ns / 1ps

interface lag_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: design/lag_ctrl.sv
`timescale 1ns / 1ps

module lag_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    input  logic [1:0]    i_req_type,
    input  lag_pkg::t_sts i_sts,
    output logic          o_req_ready,
    output lag_pkg::t_cmd o_cmd
);
    import lag_pkg::*;

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_FETCH  = 6'b000100,
        S_APPLY  = 6'b001000,
        S_GEN    = 6'b010000,
        S_RESULT = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.wr_clear = 1'b1;
                if (i_sts.clear_last) begin
                    o_cmd.cnt_clr = 1'b1;
                    n_state       = S_IDLE;
                end else begin
                    o_cmd.cnt_inc = 1'b1;
                end
            end
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.cap = 1'b1;
                    if (i_req_type inside {REQ_SET, REQ_READ}) begin
                        n_state = S_FETCH;
                    end else if (i_req_type == REQ_GEN) begin
                        n_state = S_GEN;
                    end else begin
                        n_state = S_RESULT;
                    end
                end
            end
            S_FETCH: begin
                o_cmd.rd_req = 1'b1;
                n_state      = S_APPLY;
            end
            S_APPLY: begin
                o_cmd.wr_set = 1'b1;
                n_state      = S_RESULT;
            end
            S_GEN: begin
                o_cmd.rd_gen = 1'b1;
                o_cmd.wr_gen = 1'b1;
                if (i_sts.gen_last) begin
                    o_cmd.flip    = 1'b1;
                    o_cmd.cnt_clr = 1'b1;
                    n_state       = S_RESULT;
                end else begin
                    o_cmd.cnt_inc = 1'b1;
                end
            end
            S_RESULT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

// File: design/lag_dpath.sv
`timescale 1ns / 1ps

module lag_dpath #(
    parameter int GRID_SIZE = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lag_pkg::t_req_item i_req_data,
    input  logic               i_out_ready,
    input  lag_pkg::t_cmd      i_cmd,
    output lag_pkg::t_sts      o_sts,
    output lag_pkg::t_rsp_item o_rsp_data,
    output logic               o_rsp_valid
);
    import lag_pkg::*;

    localparam int RW   = $clog2(GRID_SIZE);
    localparam int CNTW = $clog2(GRID_SIZE + 2);

    // two banks of row words
    logic [GRID_SIZE-1:0] mem [0:1][0:GRID_SIZE-1];

    logic [GRID_SIZE-1:0] r_rd;
    logic [GRID_SIZE-1:0] r_up;
    logic [GRID_SIZE-1:0] r_mid;
    logic [CNTW-1:0]      r_cnt;
    logic                 r_bank;
    t_req_item            r_req;
    t_rsp_item            r_rsp;
    logic                 r_out_valid;

    logic [RW-1:0]        w_req_row;
    logic [RW-1:0]        w_req_col;
    logic [RW-1:0]        w_gen_row;
    logic                 w_inside;
    logic                 w_border;
    logic                 w_rd_en;
    logic                 w_rd_bank;
    logic [RW-1:0]        w_rd_row;
    logic                 w_wr_en;
    logic                 w_wr_bank;
    logic [RW-1:0]        w_wr_row;
    logic [GRID_SIZE-1:0] w_wr_data;
    logic [GRID_SIZE-1:0] w_set_row;
    logic [GRID_SIZE-1:0] w_next_row;
    logic                 w_gen_wr;
    logic                 w_row_border;
    t_rsp_item            w_rsp;

    assign w_req_row = RW'(r_req.row);
    assign w_req_col = RW'(r_req.col);
    assign w_gen_row = RW'(r_cnt - CNTW'(2));

    assign w_inside = (32'(r_req.row) < 32'(GRID_SIZE)) && (32'(r_req.col) < 32'(GRID_SIZE));
    assign w_border = (r_req.row == '0) || (r_req.col == '0)
                   || (32'(r_req.row) == 32'(GRID_SIZE - 1))
                   || (32'(r_req.col) == 32'(GRID_SIZE - 1));

    assign o_sts.clear_last = (r_cnt == CNTW'(GRID_SIZE - 1));
    assign o_sts.gen_last   = (r_cnt == CNTW'(GRID_SIZE + 1));
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    // next generation of one row from the three-row window
    for (genvar c = 0; c < GRID_SIZE; c++) begin : g_cell
        if (c == 0 || c == GRID_SIZE - 1) begin : g_edge
            assign w_next_row[c] = 1'b0;
        end else begin : g_core
            logic [3:0] nsum;
            assign nsum = 4'(r_up[c-1]) + 4'(r_up[c]) + 4'(r_up[c+1])
                        + 4'(r_mid[c-1]) + 4'(r_mid[c+1])
                        + 4'(r_rd[c-1]) + 4'(r_rd[c]) + 4'(r_rd[c+1]);
            assign w_next_row[c] = (nsum == NBR_BIRTH) || (r_mid[c] && (nsum == NBR_KEEP));
        end
    end

    assign w_row_border = (r_cnt == CNTW'(2)) || (r_cnt == CNTW'(GRID_SIZE + 1));
    assign w_gen_wr     = i_cmd.wr_gen && (r_cnt >= CNTW'(2));

    always_comb begin
        w_set_row            = r_rd;
        w_set_row[w_req_col] = 1'b1;
    end

    // memory port muxing
    always_comb begin
        w_rd_en   = i_cmd.rd_req || (i_cmd.rd_gen && (r_cnt < CNTW'(GRID_SIZE)));
        w_rd_bank = r_bank;
        w_rd_row  = i_cmd.rd_gen ? r_cnt[RW-1:0] : w_req_row;

        w_wr_en   = 1'b0;
        w_wr_bank = r_bank;
        w_wr_row  = w_req_row;
        w_wr_data = w_set_row;
        if (i_cmd.wr_clear) begin
            w_wr_en   = 1'b1;
            w_wr_bank = 1'b0;
            w_wr_row  = r_cnt[RW-1:0];
            w_wr_data = '0;
        end else if (w_gen_wr) begin
            w_wr_en   = 1'b1;
            w_wr_bank = ~r_bank;
            w_wr_row  = w_gen_row;
            w_wr_data = w_row_border ? '0 : w_next_row;
        end else if (i_cmd.wr_set) begin
            w_wr_en = (r_req.req_type == REQ_SET) && w_inside && !w_border;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[w_wr_bank][w_wr_row] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd <= mem[w_rd_bank][w_rd_row];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_gen) begin
            r_up  <= r_mid;
            r_mid <= r_rd;
        end
        if (i_cmd.cap) begin
            r_req <= i_req_data;
        end
        if (i_cmd.out_load) begin
            r_rsp <= w_rsp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_bank      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.cnt_clr) begin
                r_cnt <= '0;
            end else if (i_cmd.cnt_inc) begin
                r_cnt <= r_cnt + CNTW'(1);
            end
            if (i_cmd.flip) begin
                r_bank <= ~r_bank;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        w_rsp = '0;
        case (r_req.req_type)
            REQ_READ: begin
                if (!w_inside || w_border) begin
                    w_rsp.cell_state = CELL_BORDER;
                end else begin
                    w_rsp.cell_state = r_rd[w_req_col] ? CELL_ALIVE : CELL_DEAD;
                end
            end
            REQ_GEN: begin
                w_rsp.step_done = 1'b1;
            end
            default: begin
                w_rsp = '0;
            end
        endcase
    end

    assign o_rsp_data  = r_rsp;
    assign o_rsp_valid = r_out_valid;

endmodule

// File: design/life_automaton_grid.sv
// life automaton grid, b3/s23 rule on a GRID_SIZE x GRID_SIZE square
// requests arrive on i_req (valid/ready), one answer per request leaves on o_rsp
// a request transfers when valid and ready are both high at a rising edge
// request codes: set cell alive, advance one generation, read cell state
// the outer ring is a fixed border: sets there are dropped, reads answer border
// set and read: one row word is read into a register and, for a set, written back;
//   the answer is then loaded into the output register
// generation: the row sequencer streams every row of the current bank through a
//   three-row window and writes the other bank, one row per cycle, then the banks
//   swap and the answer is loaded
// unused request code: no memory access, the answer is all zero
// only one request is in flight; i_req.ready is high only while the block idles
// the answer sits in an output register, so the block returns to idle once it
//   is loaded; a held o_rsp.ready only delays the load of the next answer
// reset (i_rst_n low, synchronous) clears the bank select and then runs a
//   clearing pass over every row of bank 0, with i_req.ready low
`timescale 1ns / 1ps
`include "assert_macros.svh"

module life_automaton_grid #(
    parameter int GRID_SIZE = 64
) (
    input logic       i_clk,
    input logic       i_rst_n,
    lag_stream_if.sink   i_req,
    lag_stream_if.source o_rsp
);
    import lag_pkg::*;

    t_cmd      w_cmd;
    t_sts      w_sts;
    t_req_item w_req_data;
    t_rsp_item w_rsp_data;
    logic      w_req_ready;
    logic      w_rsp_valid;

    assign w_req_data  = i_req.data;
    assign i_req.ready = w_req_ready;
    assign o_rsp.valid = w_rsp_valid;
    assign o_rsp.data  = w_rsp_data;

    // sequencing: clearing pass, request decode and row sweep
    lag_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_type  (w_req_data.req_type),
        .i_sts       (w_sts),
        .o_req_ready (w_req_ready),
        .o_cmd       (w_cmd)
    );

    // row memory, neighbor window, bank select and answer register
    lag_dpath #(
        .GRID_SIZE (GRID_SIZE)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_data  (w_req_data),
        .i_out_ready (o_rsp.ready),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_rsp_data  (w_rsp_data),
        .o_rsp_valid (w_rsp_valid)
    );

    // at most one write source drives the row memory
    `LAG_ASSERT_SAME(a_one_writer, 1'b1, $onehot0({w_cmd.wr_clear, w_cmd.wr_set, w_cmd.wr_gen}), "more than one memory writer")
    // an answer is never loaded over one that has not transferred
    `LAG_ASSERT_SAME(a_load_free, w_cmd.out_load, w_sts.out_free, "answer register overwritten")
    // the sweep stops writing once the banks swap
    `LAG_ASSERT_NEXT(a_flip_ends, w_cmd.flip, !w_cmd.wr_gen && !w_cmd.flip, "row sweep ran past the swap")
    // a generation answer carries no cell state
    `LAG_ASSERT_SAME(a_done_clean, o_rsp.valid && o_rsp.data.step_done, o_rsp.data.cell_state == CELL_DEAD, "generation answer with cell state")

endmodule
